// ===== hdl/arrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arrt_pkg
// shared constants and types for the aged ring record table
// ----------------------------------------------------------------------------
package arrt_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int MAX_MSG_BYTES = 512;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int MAX_WORDS     = MAX_MSG_BYTES / 4;
    localparam int WCNT_W        = $clog2(MAX_WORDS + 1);
    localparam int LEN_W         = 10;
    localparam int TAIL_WORDS    = 4;
    localparam logic [31:0] HASH_MUL = 32'd31;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_KEY   = 2'd1;
    localparam logic [1:0] ACT_SLOT  = 2'd2;
    localparam logic [1:0] ACT_HASH  = 2'd3;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FOUND   = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic CFG_ALIVE = 1'b0;
    localparam logic CFG_GUARD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_SCAN, S_STORE_RD, S_STORE_CHK, S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] service;
        logic [31:0] checksum;
        logic [31:0] hash;
        logic [7:0]  slot_id;
    } entry_t;

endpackage
`default_nettype wire

// ===== hdl/arrt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arrt_mem
// record store, one write and one registered read port
// ----------------------------------------------------------------------------
module arrt_mem (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [arrt_pkg::IDX_W-1:0] waddr,
    input  wire arrt_pkg::entry_t           wdata,
    input  wire logic [arrt_pkg::IDX_W-1:0] raddr,
    output arrt_pkg::entry_t                rdata
);
    arrt_pkg::entry_t mem [arrt_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/aged_ring_record_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aged_ring_record_table
// ring store of message records with aged search by key, slot id or hash
// ----------------------------------------------------------------------------
// Messages come in as 32-bit words on the s_ channel; words of a store or
// key search are folded into an xor checksum and a times-31 hash, four
// bytes in turn through one multiplier. Words that are not last give no
// transfer on m_. On the final word a store reads its ring slot and writes
// or refuses it; a search walks the record memory one entry a cycle from
// slot 0 and stops at the first live match or at the last slot. Searches
// by slot id or hash are single transfers.
// One item is in flight at a time; the result sits in the m_ register
// until taken, and s_tready stays low meanwhile.
// After reset the memory is cleared by a pass over all 256 entries during
// which s_tready is low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module aged_ring_record_table (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_ms, data_word, msg_len, service_key, slot_query, hash_query, pad
    input  wire logic [135:0] s_tdata,
    // action
    input  wire logic [1:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot, checksum, msg_hash
    output logic [71:0]       m_tdata,
    // status
    output logic [1:0]        m_tuser
);
    localparam int IW = arrt_pkg::IDX_W;

    logic [23:0] alive_reg, guard_reg;
    arrt_pkg::state_t state_reg, state_next;
    logic [IW:0] clr_reg;
    logic clr_done;

    logic [1:0]  act_reg;
    logic [31:0] now_reg, word_reg, hq_reg;
    logic        last_reg;
    logic [9:0]  len_reg;
    logic [15:0] key_reg;
    logic [7:0]  sq_reg;
    logic [1:0]  byte_reg;

    logic [31:0] chk_reg, hash_reg;
    logic [arrt_pkg::WCNT_W-1:0] wcnt_reg;
    logic [IW-1:0] wp_reg, scan_reg;
    logic [31:0] fchk_reg, fhash_reg;

    logic [1:0]  ost_reg;
    logic [7:0]  oslot_reg;
    logic [31:0] ochk_reg, ohash_reg;
    logic        ovalid_reg;

    logic we;
    logic [IW-1:0] waddr, raddr;
    arrt_pkg::entry_t wdata, rdata;

    arrt_mem u_mem (.aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
                    .raddr(raddr), .rdata(rdata));

    assign clr_done = clr_reg[IW];
    assign s_tready = clr_done && state_reg == arrt_pkg::S_IDLE && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ohash_reg, ochk_reg, oslot_reg};
    assign m_tuser  = ost_reg;

    wire acc = s_tvalid && s_tready;
    wire [9:0] len_in = (s_tdata[73:64] > 10'(arrt_pkg::MAX_MSG_BYTES))
        ? 10'(arrt_pkg::MAX_MSG_BYTES) : s_tdata[73:64];
    wire [31:0] age = now_reg - rdata.stamp;
    wire live = age < {8'd0, alive_reg};
    wire hit_q = (act_reg == arrt_pkg::ACT_SLOT) ? rdata.slot_id == sq_reg :
                 (act_reg == arrt_pkg::ACT_HASH) ? rdata.hash == hq_reg :
                 (rdata.service == key_reg && rdata.checksum == fchk_reg);
    wire hit = live && hit_q;
    wire scan_end = scan_reg == IW'(arrt_pkg::TABLE_DEPTH - 1);
    wire [IW-1:0] wp_inc = wp_reg + 1'b1;
    wire refuse = rdata.stamp != 32'd0 && age < {8'd0, guard_reg};
    wire sat = wcnt_reg >= arrt_pkg::WCNT_W'(arrt_pkg::MAX_WORDS);
    wire [11:0] pos = {2'd0, wcnt_reg, byte_reg};
    wire [7:0] lim = len_reg[9:2];
    wire [7:0] bval = word_reg[8'(31 - 8*byte_reg) -: 8];
    wire [31:0] hmul = hash_reg * arrt_pkg::HASH_MUL;
    wire byte_in = !sat && pos >= 12'd3 && pos < {2'd0, len_reg};
    wire chk_in = !sat && (wcnt_reg == '0 || (lim > 8'(arrt_pkg::TAIL_WORDS) &&
                  wcnt_reg < lim - 8'(arrt_pkg::TAIL_WORDS)));

    always_comb begin
        state_next = state_reg;
        we = !clr_done;
        waddr = clr_reg[IW-1:0];
        wdata = '0;
        raddr = scan_reg;
        case (state_reg)
            arrt_pkg::S_IDLE: begin
                if (acc) begin
                    if (s_tuser == arrt_pkg::ACT_SLOT || s_tuser == arrt_pkg::ACT_HASH) begin
                        state_next = arrt_pkg::S_SCAN;
                    end else begin
                        state_next = arrt_pkg::S_HASH;
                    end
                end
                raddr = '0;
            end
            arrt_pkg::S_HASH: begin
                if (byte_reg == 2'd3) begin
                    if (!last_reg) begin
                        state_next = arrt_pkg::S_IDLE;
                    end else if (act_reg == arrt_pkg::ACT_STORE) begin
                        state_next = arrt_pkg::S_STORE_RD;
                    end else begin
                        state_next = arrt_pkg::S_SCAN;
                    end
                end
                raddr = '0;
            end
            arrt_pkg::S_SCAN: begin
                raddr = scan_reg + 1'b1;
                if (hit || scan_end) begin
                    state_next = arrt_pkg::S_OUT;
                end
            end
            arrt_pkg::S_STORE_RD: begin
                raddr = wp_reg;
                state_next = arrt_pkg::S_STORE_CHK;
            end
            arrt_pkg::S_STORE_CHK: begin
                raddr = wp_reg;
                we = !refuse;
                waddr = wp_reg;
                wdata = '{stamp: now_reg, service: key_reg, checksum: fchk_reg,
                          hash: fhash_reg, slot_id: 8'(wp_reg)};
                state_next = arrt_pkg::S_OUT;
            end
            arrt_pkg::S_OUT: begin
                if (!ovalid_reg) begin
                    state_next = arrt_pkg::S_IDLE;
                end
            end
            default: state_next = arrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arrt_pkg::S_IDLE;
            clr_reg <= '0;
            alive_reg <= 24'd60000;
            guard_reg <= 24'd30000;
            ovalid_reg <= 1'b0;
            chk_reg <= '0;
            hash_reg <= '0;
            wcnt_reg <= '0;
            wp_reg <= '0;
            scan_reg <= '0;
            byte_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (!clr_done) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we && cfg_addr[0] == arrt_pkg::CFG_ALIVE) begin
                alive_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr[0] == arrt_pkg::CFG_GUARD) begin
                guard_reg <= cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                arrt_pkg::S_IDLE: begin
                    byte_reg <= '0;
                    scan_reg <= '0;
                end
                arrt_pkg::S_HASH: begin
                    byte_reg <= byte_reg + 1'b1;
                    if (byte_reg == 2'd0 && chk_in) begin
                        chk_reg <= chk_reg ^ word_reg;
                    end
                    if (byte_in) begin
                        hash_reg <= hmul + {24'd0, bval};
                    end
                    if (byte_reg == 2'd3) begin
                        if (!sat) begin
                            wcnt_reg <= wcnt_reg + 1'b1;
                        end
                        if (last_reg) begin
                            chk_reg <= '0;
                            hash_reg <= '0;
                            wcnt_reg <= '0;
                            if (act_reg == arrt_pkg::ACT_STORE) begin
                                wp_reg <= wp_inc;
                            end
                        end
                    end
                end
                arrt_pkg::S_SCAN: begin
                    scan_reg <= scan_reg + 1'b1;
                    if (hit || scan_end) begin
                        ovalid_reg <= 1'b1;
                    end
                end
                arrt_pkg::S_STORE_CHK: begin
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            act_reg  <= s_tuser;
            now_reg  <= s_tdata[31:0];
            word_reg <= s_tdata[63:32];
            len_reg  <= len_in;
            key_reg  <= s_tdata[89:74];
            sq_reg   <= s_tdata[97:90];
            hq_reg   <= s_tdata[129:98];
            last_reg <= s_tlast;
            if (s_tuser == arrt_pkg::ACT_SLOT || s_tuser == arrt_pkg::ACT_HASH) begin
                fchk_reg  <= '0;
                fhash_reg <= '0;
            end
        end
        if (state_reg == arrt_pkg::S_HASH && byte_reg == 2'd3) begin
            fchk_reg  <= (chk_in) ? chk_reg : chk_reg;
            fhash_reg <= byte_in ? hmul + {24'd0, bval} : hash_reg;
        end
        if (state_reg == arrt_pkg::S_SCAN && (hit || scan_end)) begin
            ost_reg   <= hit ? arrt_pkg::ST_FOUND : arrt_pkg::ST_NONE;
            oslot_reg <= hit ? 8'(scan_reg) : 8'd0;
            ochk_reg  <= fchk_reg;
            ohash_reg <= fhash_reg;
        end
        if (state_reg == arrt_pkg::S_STORE_CHK) begin
            ost_reg   <= refuse ? arrt_pkg::ST_REFUSED : arrt_pkg::ST_STORED;
            oslot_reg <= 8'(wp_reg);
            ochk_reg  <= fchk_reg;
            ohash_reg <= fhash_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_done |-> !s_tready) else $error("input taken during clear");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_aged_ring_record_table.sv =====
// ----------------------------------------------------------------------------
// tb_aged_ring_record_table
// self-checking testbench for the aged ring record table
// ----------------------------------------------------------------------------
// Messages, stores and searches are sent on the s_ channel. A predictor in the
// testbench keeps its own copy of the record table, the running checksum and hash,
// and the settings of the two age registers. Every m_ transfer is compared field by
// field with the oldest predicted result. Both sides idle in random bursts while
// idle_on is set. The age registers are written only while the block is idle.
// ----------------------------------------------------------------------------
module tb_aged_ring_record_table;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] checksum;
        logic [31:0] msg_hash;
    } table_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [0:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;

    aged_ring_record_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // predictor state
    logic [23:0] alive_win;
    logic [23:0] guard_win;
    logic [7:0]  ring_ptr;
    logic [31:0] rec_stamp [arrt_pkg::TABLE_DEPTH];
    logic [15:0] rec_service [arrt_pkg::TABLE_DEPTH];
    logic [31:0] rec_checksum [arrt_pkg::TABLE_DEPTH];
    logic [31:0] rec_hash [arrt_pkg::TABLE_DEPTH];
    logic [7:0]  rec_slot_id [arrt_pkg::TABLE_DEPTH];
    logic [31:0] acc_checksum;
    logic [31:0] acc_hash;
    int unsigned acc_words;

    table_result_t pending_results[$];
    int  errors;
    int  quiet_cycles;
    bit  idle_on;
    logic [31:0] clock_ms;
    logic [31:0] hash_pool[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit record_live(int idx, logic [31:0] now);
        logic [31:0] age;
        age = now - rec_stamp[idx];
        return age < {8'd0, alive_win};
    endfunction

    task automatic fold_word(logic [31:0] w, int unsigned len);
        int unsigned limit;
        int unsigned pos;
        limit = len / 4;
        if (acc_words >= arrt_pkg::MAX_WORDS) return;
        if (acc_words == 0 || (limit > arrt_pkg::TAIL_WORDS &&
                               acc_words < limit - arrt_pkg::TAIL_WORDS))
            acc_checksum ^= w;
        for (int b = 0; b < 4; b++) begin
            pos = acc_words * 4 + b;
            if (pos >= 3 && pos < len)
                acc_hash = acc_hash * arrt_pkg::HASH_MUL + 32'(w[31 - 8 * b -: 8]);
        end
        acc_words++;
    endtask

    task automatic predict_table(logic [1:0] act, logic [31:0] now, logic [31:0] w,
                                 bit last, logic [9:0] len_in, logic [15:0] key,
                                 logic [7:0] sq, logic [31:0] hq);
        table_result_t r;
        int unsigned len;
        logic [31:0] chk;
        logic [31:0] h;
        logic [7:0] p;
        bit hit;
        len = (len_in > arrt_pkg::MAX_MSG_BYTES) ? arrt_pkg::MAX_MSG_BYTES : len_in;
        r = '0;
        hit = 0;
        if (act == arrt_pkg::ACT_SLOT || act == arrt_pkg::ACT_HASH) begin
            r.status = arrt_pkg::ST_NONE;
            for (int i = 0; i < arrt_pkg::TABLE_DEPTH && !hit; i++) begin
                if (record_live(i, now) &&
                    ((act == arrt_pkg::ACT_SLOT) ? rec_slot_id[i] == sq
                                                 : rec_hash[i] == hq)) begin
                    r.status = arrt_pkg::ST_FOUND;
                    r.slot = 8'(i);
                    hit = 1;
                end
            end
            pending_results.push_back(r);
            return;
        end
        fold_word(w, len);
        if (!last) return;
        chk = acc_checksum;
        h = acc_hash;
        acc_checksum = '0;
        acc_hash = '0;
        acc_words = 0;
        r.checksum = chk;
        r.msg_hash = h;
        if (act == arrt_pkg::ACT_STORE) begin
            p = ring_ptr + 8'd1;
            ring_ptr = p;
            r.slot = p;
            if (rec_stamp[p] != 0 && (now - rec_stamp[p]) < {8'd0, guard_win}) begin
                r.status = arrt_pkg::ST_REFUSED;
            end else begin
                rec_stamp[p] = now;
                rec_service[p] = key;
                rec_checksum[p] = chk;
                rec_hash[p] = h;
                rec_slot_id[p] = p;
                r.status = arrt_pkg::ST_STORED;
                hash_pool.push_back(h);
            end
        end else begin
            r.status = arrt_pkg::ST_NONE;
            for (int i = 0; i < arrt_pkg::TABLE_DEPTH && !hit; i++) begin
                if (record_live(i, now) && rec_service[i] == key && rec_checksum[i] == chk) begin
                    r.status = arrt_pkg::ST_FOUND;
                    r.slot = 8'(i);
                    hit = 1;
                end
            end
        end
        pending_results.push_back(r);
    endtask

    task automatic send_item(logic [1:0] act, logic [31:0] now, logic [31:0] w, bit last,
                             logic [9:0] len, logic [15:0] key, logic [7:0] sq,
                             logic [31:0] hq);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tlast <= last;
        s_tdata <= {6'd0, hq, sq, key, len, w, now};
        predict_table(act, now, w, last, len, key, sq, hq);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // full message as a run of words; len may be short or long against the word count
    task automatic send_message(logic [1:0] act, logic [31:0] now, int unsigned len,
                                int unsigned words, logic [15:0] key);
        for (int i = 0; i < words; i++)
            send_item(act, now, $urandom(), i == words - 1, 10'(len), key,
                      8'($urandom()), $urandom());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == arrt_pkg::CFG_ALIVE) alive_win = val;
        else guard_win = val;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        // zeroed table counts as live while now is small
        send_item(arrt_pkg::ACT_SLOT, 32'd0, '0, 1'b0, 10'd4, '0, 8'd0, '0);
        send_item(arrt_pkg::ACT_HASH, 32'd5, '0, 1'b0, 10'd4, '0, '0, 32'd0);
        send_item(arrt_pkg::ACT_SLOT, 32'hFFFF_FFFF, '1, 1'b1, 10'h3FF, '1, 8'hFF, '1);
        send_item(arrt_pkg::ACT_HASH, 32'hFFFF_FFFF, '1, 1'b1, 10'h3FF, '1, '1,
                  32'hFFFF_FFFF);
        send_message(arrt_pkg::ACT_STORE, 32'd100, 4, 1, 16'h0000);
        send_message(arrt_pkg::ACT_STORE, 32'd200, 0, 1, 16'hFFFF);
        send_message(arrt_pkg::ACT_STORE, 32'd300, 24, 6, 16'h1234);
        send_message(arrt_pkg::ACT_KEY, 32'd400, 24, 6, 16'h1234);
        send_message(arrt_pkg::ACT_KEY, 32'd400, 4, 1, 16'h0000);
        // short message and overlong length
        send_message(arrt_pkg::ACT_STORE, 32'd500, 40, 3, 16'hA5A5);
        send_message(arrt_pkg::ACT_STORE, 32'hFFFF_FFF0, 1023, 2, 16'h5A5A);
        send_item(arrt_pkg::ACT_SLOT, 32'd600, '0, 1'b0, 10'd4, '0, 8'd3, '0);
        send_item(arrt_pkg::ACT_HASH, 32'd600, '0, 1'b0, 10'd4, '0, '0, hash_pool[$]);
        // four stores at one time into slots not yet written
        for (int i = 0; i < 4; i++)
            send_message(arrt_pkg::ACT_STORE, 32'd700, 8, 2, 16'(i));
        wait_drained();
    endtask

    task automatic test_overlong();
        // words past the word limit are dropped
        send_message(arrt_pkg::ACT_STORE, 32'd1000, 512, 130, 16'h0F0F);
        send_message(arrt_pkg::ACT_KEY, 32'd1000, 600, 129, 16'h0F0F);
        wait_drained();
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned words;
        int kind;
        logic [31:0] hq;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            clock_ms += $urandom_range(0, 6000);
            if ($urandom_range(0, 40) == 0) clock_ms = $urandom();
            if (kind < 6) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(4, 40);
                words = (len + 3) / 4;
                if (words > 12 || words == 0) words = $urandom_range(1, 12);
                if ($urandom_range(0, 7) == 0) words = $urandom_range(1, 12);
                send_message(kind < 4 ? arrt_pkg::ACT_STORE : arrt_pkg::ACT_KEY, clock_ms,
                             len, words, 16'($urandom_range(0, 7)));
                sent += words;
            end else if (kind < 8) begin
                send_item(arrt_pkg::ACT_SLOT, clock_ms, $urandom(),
                          1'($urandom_range(0, 1)), 10'($urandom()), 16'($urandom()),
                          8'($urandom()), $urandom());
                sent++;
            end else begin
                hq = (hash_pool.size() != 0 && $urandom_range(0, 2) != 0)
                     ? hash_pool[$urandom_range(0, hash_pool.size() - 1)] : $urandom();
                send_item(arrt_pkg::ACT_HASH, clock_ms, $urandom(),
                          1'($urandom_range(0, 1)), 10'($urandom()), 16'($urandom()),
                          8'($urandom()), hq);
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_window_settings();
        write_reg(arrt_pkg::CFG_ALIVE, 24'd0);
        write_reg(arrt_pkg::CFG_GUARD, 24'd0);
        test_random(120);
        write_reg(arrt_pkg::CFG_ALIVE, 24'hFF_FFFF);
        write_reg(arrt_pkg::CFG_GUARD, 24'hFF_FFFF);
        test_random(120);
        write_reg(arrt_pkg::CFG_ALIVE, 24'(20000));
        write_reg(arrt_pkg::CFG_GUARD, 24'(5000));
        test_random(250);
        write_reg(arrt_pkg::CFG_ALIVE, 24'(60000));
        write_reg(arrt_pkg::CFG_GUARD, 24'(30000));
    endtask

    // result checking
    always @(posedge aclk) begin
        table_result_t exp_r;
        table_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[71:40]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    errors++;
                end
                if (got.slot !== exp_r.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, exp_r.slot, got.slot);
                    errors++;
                end
                if (got.checksum !== exp_r.checksum) begin
                    $display("%0t: checksum exp %h got %h", $time, exp_r.checksum,
                             got.checksum);
                    errors++;
                end
                if (got.msg_hash !== exp_r.msg_hash) begin
                    $display("%0t: msg_hash exp %h got %h", $time, exp_r.msg_hash,
                             got.msg_hash);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        clock_ms = 32'd1000;
        alive_win = 24'(60000);
        guard_win = 24'(30000);
        ring_ptr = '0;
        acc_checksum = '0;
        acc_hash = '0;
        acc_words = 0;
        for (int i = 0; i < arrt_pkg::TABLE_DEPTH; i++) begin
            rec_stamp[i] = '0;
            rec_service[i] = '0;
            rec_checksum[i] = '0;
            rec_hash[i] = '0;
            rec_slot_id[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overlong();
        test_window_settings();
        test_random(200);
        idle_on = 1'b0;
        test_random(160);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
